/* sv/olt_pkg.sv */
// Shared types and constants for the ordered list table.
package olt_pkg;

  // Number of cells in the list
  localparam int CAPACITY = 64;
  // Count runs 0..CAPACITY
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int OP_W     = 3;
  localparam int ST_W     = 2;
  // Common width for comparing the position field against the count
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_PREPEND = 3'd1,
    OP_INSERT  = 3'd2,
    OP_DELETE  = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // Request beat
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } req_t;

  // Response beat
  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
  } rsp_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic             ins;     // insert accepted, list not full
    logic [CNT_W-1:0] at;      // insert slot
    logic             del;     // delete request accepted
    logic             rd;      // in-range read
    logic [CNT_W-1:0] rd_idx;  // read slot
    logic [CNT_W-1:0] count;   // current length
    logic [VAL_W-1:0] value;   // insert or match value
  } cell_ctl_t;

endpackage

/* sv/olt_cell.sv */
// One slot of the ordered list: holds an element, shifts with its neighbors.
module olt_cell
  import olt_pkg::*;
(
  input  logic             clk,
  input  logic [CNT_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  logic [VAL_W-1:0] left_data,
  input  logic [VAL_W-1:0] right_data,
  input  logic             found_in,
  input  logic [VAL_W-1:0] rd_in,
  output logic [VAL_W-1:0] data,
  output logic             found_out,
  output logic [VAL_W-1:0] rd_out
);

  logic             occupied;
  logic             match;
  logic [VAL_W-1:0] data_next;

  assign occupied = (idx < ctl.count);

  // Delete search: first match marks this cell and all cells after it
  assign match     = ctl.del && occupied && (data == ctl.value);
  assign found_out = found_in | match;

  // Read: the addressed cell ORs its element into the passing word
  assign rd_out = rd_in | ((ctl.rd && (idx == ctl.rd_idx)) ? data : '0);

  // Shift up behind an insert, shift down from the deleted slot
  always_comb begin
    data_next = data;
    if (ctl.ins) begin
      if (idx > ctl.at) begin
        data_next = left_data;
      end else if (idx == ctl.at) begin
        data_next = ctl.value;
      end
    end else if (ctl.del && found_out) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* sv/ordered_list_table_top.sv */
// Top level of the ordered list table: request decode, cell row, response register.
//
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// one element per cell. Every request (append, prepend, insert at position,
// delete first match, read at position) is carried out in the cycle it is
// accepted: all cells shift and compare in parallel, and the delete search and
// read select ripple along the row. The response appears in the output
// register in the cycle after the request beat and stays until taken; a new
// request is accepted in the same cycle the pending response is taken, so the
// block sustains one operation per clock while responses are taken. The length
// in each response is the list length after that operation, modulo 128.
module ordered_list_table_top
  import olt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic             accept;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             is_ins;
  logic             full;
  logic             pos_in_range;
  logic [CNT_W-1:0] ins_at;
  logic             del_hit;
  cell_ctl_t        ctl;
  rsp_t             rsp_next;

  logic [VAL_W-1:0] cell_data [CAPACITY];
  logic             found     [CAPACITY+1];
  logic [VAL_W-1:0] rd_chain  [CAPACITY+1];

  // Handshake: take a request when the response slot is free or draining
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  // Request decode
  assign is_ins = accept && ((req.op == OP_APPEND) || (req.op == OP_PREPEND) ||
                             (req.op == OP_INSERT));
  assign full   = (count >= CNT_W'(CAPACITY));
  assign pos_in_range = (CMP_W'(req.position) < CMP_W'(count));

  always_comb begin
    case (req.op)
      OP_PREPEND: ins_at = '0;
      OP_INSERT:  ins_at = pos_in_range ? CNT_W'(req.position) : count;
      default:    ins_at = count;
    endcase
  end

  always_comb begin
    ctl        = '0;
    ctl.ins    = is_ins && !full;
    ctl.at     = ins_at;
    ctl.del    = accept && (req.op == OP_DELETE);
    ctl.rd     = accept && (req.op == OP_READ) && pos_in_range;
    ctl.rd_idx = CNT_W'(req.position);
    ctl.count  = count;
    ctl.value  = req.value;
  end

  // Cell row
  assign found[0]    = 1'b0;
  assign rd_chain[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_data;
    logic [VAL_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    olt_cell u_cell (
      .clk        (clk),
      .idx        (CNT_W'(i)),
      .ctl        (ctl),
      .left_data  (left_data),
      .right_data (right_data),
      .found_in   (found[i]),
      .rd_in      (rd_chain[i]),
      .data       (cell_data[i]),
      .found_out  (found[i+1]),
      .rd_out     (rd_chain[i+1])
    );
  end

  assign del_hit = found[CAPACITY];

  // Length update and response
  always_comb begin
    count_next          = count;
    rsp_next.status     = ST_OK;
    rsp_next.read_value = '0;
    if (is_ins) begin
      if (full) begin
        rsp_next.status = ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else if (ctl.del) begin
      if (del_hit) begin
        count_next = count - CNT_W'(1);
      end else begin
        rsp_next.status = ST_MISS;
      end
    end else if (accept && (req.op == OP_READ)) begin
      if (pos_in_range) begin
        rsp_next.read_value = rd_chain[CAPACITY];
      end else begin
        rsp_next.status = ST_MISS;
      end
    end
    rsp_next.length = LEN_W'(count_next);
  end

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (is_ins && full) |=> (rsp.status == ST_FULL) && (count == $past(count)))
    else $error("insert into full list not dropped");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    (is_ins && !full) |=> (count == $past(count) + CNT_W'(1)) && (rsp.status == ST_OK))
    else $error("insert did not grow the list");

  a_del_miss: assert property (@(posedge clk) disable iff (rst)
    (ctl.del && !del_hit) |=> (rsp.status == ST_MISS) && (count == $past(count)))
    else $error("missed delete changed the list");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the ordered list table: directed, fill, random and stall tests.
`timescale 1ns / 1ps

module tb_top
  import olt_pkg::*;
;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  // Op codes that the block ignores
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Shadow copy of the list and the responses still owed by the block
  logic [VAL_W-1:0] list_vals [CAPACITY];
  int unsigned      list_len = 0;
  rsp_t             expected_rsps [$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // Sender pacing
  bit          pace_on    = 1'b1;
  int unsigned burst_left = 0;

  // Receiver pattern and long hold-off
  rx_mode_t    stall_mode = RX_OPEN;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen  = 0;

  ordered_list_table_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Applies one request to the shadow list and returns the response it owes
  function automatic rsp_t predict_response(req_t r);
    rsp_t        o;
    int unsigned at;
    int unsigned i;
    o.status     = ST_OK;
    o.read_value = '0;
    case (r.op)
      OP_APPEND, OP_PREPEND, OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          if (r.op == OP_APPEND) at = list_len;
          else if (r.op == OP_PREPEND) at = 0;
          else at = (r.position >= list_len) ? list_len : r.position;
          for (i = list_len; i > at; i--) list_vals[i] = list_vals[i - 1];
          list_vals[at] = r.value;
          list_len++;
        end
      end
      OP_DELETE: begin
        i = 0;
        while (i < list_len && list_vals[i] != r.value) i++;
        if (i >= list_len) begin
          o.status = ST_MISS;
        end else begin
          while (i + 1 < list_len) begin
            list_vals[i] = list_vals[i + 1];
            i++;
          end
          list_len--;
        end
      end
      OP_READ: begin
        if (r.position < list_len) o.read_value = list_vals[r.position];
        else o.status = ST_MISS;
      end
      default: ;  // unused codes leave the list alone
    endcase
    o.length = LEN_W'(list_len);
    return o;
  endfunction

  // Extremes, a small pool that makes duplicates, and full-range values
  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4, 5:    return VAL_W'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  // Drives one request beat, waits for the handshake, then maybe idles
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                           input logic [POS_W-1:0] position);
    req_t        r;
    int unsigned gap;
    r.op       = op;
    r.value    = value;
    r.position = position;
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    expected_rsps.push_back(predict_response(r));
    if (pace_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 6);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // One random request; grow_pct steers the list length up or down
  task automatic random_item(input int unsigned grow_pct);
    int unsigned      roll;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] del_val;
    if ($urandom_range(0, 4) == 0 || list_len + 1 > 127) pos = $urandom_range(0, 127);
    else pos = $urandom_range(0, list_len + 1);
    roll = $urandom_range(0, 99);
    if (roll < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       send_item(OP_APPEND, rand_value(), pos);
        1:       send_item(OP_PREPEND, rand_value(), pos);
        default: send_item(OP_INSERT, rand_value(), pos);
      endcase
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        // mostly hit an element that is present
        if (list_len != 0 && $urandom_range(0, 3) != 0)
          del_val = list_vals[$urandom_range(0, list_len - 1)];
        else
          del_val = rand_value();
        send_item(OP_DELETE, del_val, pos);
      end else if (roll < 95) begin
        send_item(OP_READ, rand_value(), pos);
      end else begin
        case ($urandom_range(0, 2))
          0:       send_item(OP_RSVD5, rand_value(), pos);
          1:       send_item(OP_RSVD6, rand_value(), pos);
          default: send_item(OP_RSVD7, rand_value(), pos);
        endcase
      end
    end
  endtask

  // Empty list, extremes, insert positions at the ends, duplicates, misses, unused ops
  task automatic test_directed_cases();
    send_item(OP_READ, '0, 0);
    send_item(OP_DELETE, '0, 0);
    send_item(OP_APPEND, 32'h7fff_ffff, 0);
    send_item(OP_PREPEND, 32'h8000_0000, 5);
    send_item(OP_INSERT, 32'hffff_ffff, 1);
    send_item(OP_INSERT, '0, 0);
    send_item(OP_INSERT, 32'd1, 7'd127);
    send_item(OP_INSERT, 32'd5, POS_W'(list_len));
    send_item(OP_APPEND, 32'd5, 0);
    send_item(OP_READ, '0, 0);
    send_item(OP_READ, '1, 6);
    send_item(OP_READ, '0, 7);
    send_item(OP_READ, '0, 7'd127);
    send_item(OP_DELETE, 32'd5, 0);
    send_item(OP_READ, '0, 5);
    send_item(OP_DELETE, 32'd12345, 0);
    send_item(OP_DELETE, 32'h8000_0000, 0);
    send_item(OP_DELETE, 32'h7fff_ffff, 7'd127);
    send_item(OP_RSVD5, 32'h7fff_ffff, 7'd127);
    send_item(OP_RSVD6, 32'h8000_0000, 0);
    send_item(OP_RSVD7, '1, 7'd64);
    send_item(OP_READ, '0, 7'd64);
  endtask

  // Grow to capacity, hit the full list with every insert op, then drain to two elements
  task automatic test_fill_and_drain();
    while (list_len < CAPACITY) random_item(90);
    send_item(OP_APPEND, rand_value(), 0);
    send_item(OP_PREPEND, rand_value(), 0);
    send_item(OP_INSERT, rand_value(), 7'd10);
    send_item(OP_INSERT, rand_value(), 7'd127);
    send_item(OP_READ, '0, POS_W'(CAPACITY - 1));
    send_item(OP_READ, '0, POS_W'(CAPACITY));
    repeat (4) random_item(100);
    while (list_len > 2) random_item(10);
  endtask

  // Mixed traffic with the growth bias moving between phases
  task automatic test_random_mix();
    repeat (50) random_item(30);
    pace_on = 1'b0;
    repeat (50) random_item(60);
    pace_on = 1'b1;
    repeat (50) random_item(45);
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    pace_on = 1'b0;
    hold_token <= hold_token + 1;
    repeat (40) random_item(50);
    pace_on = 1'b1;
  endtask

  // Receiver: changing stall pattern, plus the long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(8, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        RX_OPEN:   rsp_ready <= 1'b1;
        RX_COIN:   rsp_ready <= $urandom_range(0, 1);
        RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
        default:   rsp_ready <= ~rsp_ready;
      endcase
    end
  end

  // Compare every response beat against the oldest expectation
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual status %0d value %0d length %0d",
                 $time, rsp.status, rsp.read_value, rsp.length);
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, rsp.status);
          fail_count++;
        end
        if (rsp.read_value !== want.read_value) begin
          $display("%0t: read_value mismatch: expected %0d actual %0d",
                   $time, want.read_value, rsp.read_value);
          fail_count++;
        end
        if (rsp.length !== want.length) begin
          $display("%0t: length mismatch: expected %0d actual %0d",
                   $time, want.length, rsp.length);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ordered_list_table_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_fill_and_drain();
    test_random_mix();
    test_backpressure();
    test_random_mix();
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ordered_list_table_top test passed");
    end else begin
      $display("ordered_list_table_top test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/olt_pkg.sv
sv/olt_cell.sv
sv/ordered_list_table_top.sv
tb/tb_top.sv
